/* rtl/tia_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tia_pkg: shared types and constants
// Beat payloads, symbol alphabet sizing, register indexes, character codes.
// ----------------------------------------------------------------------------
package tia_pkg;

  localparam int MaxSymbols = 16;
  localparam int SymPerWord = 8;
  localparam int IdxW       = $clog2(MaxSymbols);
  localparam int CountW     = 5;
  localparam int ValueW     = 64;
  localparam int CfgAddrW   = 2;

  // Register indexes of the configuration port
  localparam logic [CfgAddrW-1:0] CfgSymbolsLow  = 2'd0;
  localparam logic [CfgAddrW-1:0] CfgSymbolsHigh = 2'd1;
  localparam logic [CfgAddrW-1:0] CfgSymbolCount = 2'd2;

  // Character codes
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChCr    = 8'h0D;

  typedef logic [MaxSymbols-1:0][7:0] sym_arr_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } in_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     base_ok;
  } out_t;

  // Classification of one character against the alphabet
  typedef struct packed {
    logic            hit;
    logic [IdxW-1:0] idx;
    logic            space;
    logic            sign;
    logic            minus;
  } match_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChLf) ||
           (c == ChVt) || (c == ChFf) || (c == ChCr);
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return (c == ChPlus) || (c == ChMinus);
  endfunction

endpackage

/* rtl/tia_symbol_match.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tia_symbol_match: character classifier
// Parallel compare against all symbols in use; lowest matching index wins.
// ----------------------------------------------------------------------------
module tia_symbol_match
  import tia_pkg::*;
(
  input  logic [7:0]        char_i,
  input  sym_arr_t          syms_i,
  input  logic [CountW-1:0] used_i,
  output match_t            match_o
);

  always_comb begin
    match_o       = '0;
    match_o.space = is_space(char_i);
    match_o.sign  = is_sign(char_i);
    match_o.minus = (char_i == ChMinus);
    // scan downward so the lowest index is left standing
    for (int i = MaxSymbols - 1; i >= 0; i--) begin
      if ((CountW'(i) < used_i) && (syms_i[i] == char_i)) begin
        match_o.hit = 1'b1;
        match_o.idx = IdxW'(i);
      end
    end
  end

endmodule

/* rtl/tia_alphabet_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tia_alphabet_check: alphabet validity
// Count in range, no zero, sign or whitespace symbol, no duplicates.
// ----------------------------------------------------------------------------
module tia_alphabet_check
  import tia_pkg::*;
(
  input  sym_arr_t          syms_i,
  input  logic [CountW-1:0] count_i,
  output logic              ok_o
);

  logic [MaxSymbols-1:0] bad;

  always_comb begin
    for (int i = 0; i < MaxSymbols; i++) begin
      bad[i] = (syms_i[i] == ChNul) || is_sign(syms_i[i]) || is_space(syms_i[i]);
      for (int j = 0; j < i; j++) begin
        if (syms_i[j] == syms_i[i]) bad[i] = 1'b1;
      end
      // only symbols in use count
      if (CountW'(i) >= count_i) bad[i] = 1'b0;
    end
  end

  assign ok_o = (count_i >= CountW'(2)) && (count_i <= CountW'(MaxSymbols)) && !(|bad);

endmodule

/* rtl/tia_parse_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tia_parse_core: parse state and accumulator
// Phase, sign and running value; one multiply-add per digit beat.
// ----------------------------------------------------------------------------
module tia_parse_core
  import tia_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  in_t               data_i,
  input  match_t            match_i,
  input  logic [CountW-1:0] radix_i,
  output logic [ValueW-1:0] value_o
);

  typedef enum logic [1:0] {
    PhSpace,
    PhSign,
    PhDigit,
    PhStop
  } phase_e;

  phase_e            phase_q, phase_d;
  logic              neg_q, neg_d;
  logic [ValueW-1:0] acc_q, acc_d;
  logic [ValueW-1:0] take;
  logic              is_nul;
  logic              ends;
  logic              neg_f;
  logic [ValueW-1:0] acc_f;

  assign take   = (acc_q * ValueW'(radix_i)) + ValueW'(match_i.idx);
  assign is_nul = (data_i.character == ChNul);
  assign ends   = is_nul || data_i.last;

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    case (phase_q)
      PhSpace: begin
        if (match_i.space) begin
          phase_d = PhSpace;
        end else if (match_i.sign) begin
          if (match_i.minus) neg_d = !neg_q;
          phase_d = PhSign;
        end else if (match_i.hit) begin
          acc_d   = take;
          phase_d = PhDigit;
        end else begin
          phase_d = PhStop;
        end
      end
      PhSign: begin
        if (match_i.sign) begin
          if (match_i.minus) neg_d = !neg_q;
        end else if (match_i.hit) begin
          acc_d   = take;
          phase_d = PhDigit;
        end else begin
          phase_d = PhStop;
        end
      end
      PhDigit: begin
        if (match_i.hit) acc_d = take;
        else phase_d = PhStop;
      end
      default: begin
        phase_d = PhStop;
      end
    endcase
  end

  // a NUL beat ends the string without being parsed
  assign neg_f   = is_nul ? neg_q : neg_d;
  assign acc_f   = is_nul ? acc_q : acc_d;
  assign value_o = neg_f ? (ValueW'(0) - acc_f) : acc_f;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSpace;
      neg_q   <= 1'b0;
      acc_q   <= '0;
    end else if (fire_i) begin
      if (ends) begin
        phase_q <= PhSpace;
        neg_q   <= 1'b0;
        acc_q   <= '0;
      end else begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        acc_q   <= acc_d;
      end
    end
  end

endmodule

/* rtl/text_to_integer_any_base.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_to_integer_any_base: signed integer parser over a custom digit alphabet
// A beat is first held in the input register and parsed from there; its
// result, if any, is captured in the result register as it is parsed.
// Throughput: one character per cycle, except that a string-ending beat waits
// for a free result slot; set by the accumulator's multiply-add (value * radix + index).
// Reset: asynchronous, clears parse state, pipeline valids and configuration registers.
// ----------------------------------------------------------------------------
module text_to_integer_any_base
  import tia_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [ValueW-1:0]   cfg_wdata_i,
  // character beats in
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_data_i,
  // result beats out
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [ValueW-1:0] sym_low_q;
  logic [ValueW-1:0] sym_high_q;
  logic [CountW-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_low_q  <= '0;
      sym_high_q <= '0;
      count_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgSymbolsLow:  sym_low_q  <= cfg_wdata_i;
        CfgSymbolsHigh: sym_high_q <= cfg_wdata_i;
        CfgSymbolCount: count_q    <= cfg_wdata_i[CountW-1:0];
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

  // symbol 0 sits in the lowest byte of the low word
  sym_arr_t          syms;
  logic [CountW-1:0] used;

  assign syms = {sym_high_q, sym_low_q};
  // a count above the alphabet size saturates for matching and radix
  assign used = (count_q > CountW'(MaxSymbols)) ? CountW'(MaxSymbols) : count_q;

  // --------------------------------------------------------------------------
  // Input register: hold one beat ahead of the parser
  // --------------------------------------------------------------------------
  logic s1_valid_q;
  in_t  s1_data_q;
  logic s1_emit;
  logic s1_fire;
  logic out_free;

  assign out_free   = !out_valid_o || out_ready_i;
  // beats that end a string need a free result slot, others always advance
  assign s1_emit    = s1_data_q.last || (s1_data_q.character == ChNul);
  assign s1_fire    = s1_valid_q && (!s1_emit || out_free);
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_data_q <= in_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Classify, check alphabet, advance parse state
  // --------------------------------------------------------------------------
  match_t            match;
  logic              base_ok;
  logic [ValueW-1:0] value;

  tia_symbol_match u_match (
    .char_i  (s1_data_q.character),
    .syms_i  (syms),
    .used_i  (used),
    .match_o (match)
  );

  tia_alphabet_check u_check (
    .syms_i  (syms),
    .count_i (count_q),
    .ok_o    (base_ok)
  );

  tia_parse_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (s1_fire),
    .data_i  (s1_data_q),
    .match_i (match),
    .radix_i (used),
    .value_o (value)
  );

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic out_valid_q;
  out_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_emit) begin
      out_data_q.value   <= $signed(value);
      out_data_q.base_ok <= base_ok;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // back-pressure on the input only when a beat is parked
  a_ready_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

  // a string end always lands in the result register
  a_emit_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_emit |=> out_valid_o)
    else $error("string end produced no result beat");

  // a valid alphabet implies a symbol count in range
  a_ok_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_ok |-> (count_q >= CountW'(2)) && (count_q <= CountW'(MaxSymbols)))
    else $error("alphabet reported valid with count out of range");

endmodule
